// ===== src/uf_pkg.sv =====
// Package for the union-find table: sizes, operation codes and the
// command and response structs between the sequencer and the table.
// No dependencies.
package uf_pkg;

    localparam int UF_SIZE   = 16;
    localparam int UF_IDX_W  = $clog2(UF_SIZE);
    localparam int UF_CNT_W  = $clog2(UF_SIZE + 1);
    localparam int UF_RANK_W = 3;
    localparam int UF_ELEM_W = 4;
    localparam int UF_CFG_W  = 5;
    localparam int UF_ACT_W  = 2;

    localparam logic [UF_RANK_W-1:0] UF_RANK_MAX = '1;

    typedef enum logic [UF_ACT_W-1:0] {
        OP_INIT  = 2'd0,
        OP_QUERY = 2'd1,
        OP_UNION = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [UF_IDX_W-1:0]  rd_addr;
        logic                 par_we;
        logic [UF_IDX_W-1:0]  par_addr;
        logic [UF_IDX_W-1:0]  par_data;
        logic                 rank_we;
        logic [UF_IDX_W-1:0]  rank_addr;
        logic [UF_RANK_W-1:0] rank_data;
    } tbl_cmd_t;

    typedef struct packed {
        logic [UF_IDX_W-1:0]  parent;
        logic [UF_RANK_W-1:0] rank;
    } tbl_rsp_t;

endpackage

// ===== src/union_find_rank_compress.sv =====
// Top level of the union-find table: config register, sequencer and storage.
// Depends on uf_pkg, uf_table and uf_seq.
//
// Disjoint-set table of 16 elements with union by rank and path compression.
// One beat is taken at a time; s_tready is high only while the block is idle.
// An init beat resets the first n entries (n the active element count, the
// smaller of set_count and 16). A query or union beat walks element a to its
// root and compresses that path, then does the same for element b, and a
// union of two different roots then reads both ranks and links them; every
// step goes through the single read port of the parent table. Errors and
// unused actions go straight to the done state. Results are held in
// an output register so the next beat may be taken while one waits.
module union_find_rank_compress (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // set_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // elem_a[3:0], elem_b[7:4]
    input  logic [1:0]  s_tuser,      // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // connected[0], leader_a[4:1], leader_b[8:5], zero
    output logic        m_tuser       // status
);

    logic [uf_pkg::UF_CFG_W-1:0]  set_count_reg;
    uf_pkg::tbl_cmd_t             cmd;
    uf_pkg::tbl_rsp_t             rsp;
    logic                         connected;
    logic [uf_pkg::UF_ELEM_W-1:0] leader_a;
    logic [uf_pkg::UF_ELEM_W-1:0] leader_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_count_reg <= uf_pkg::UF_CFG_W'(uf_pkg::UF_SIZE);
        end else if (cfg_valid && cfg_ready) begin
            set_count_reg <= cfg_data;
        end
    end

    uf_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    uf_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .set_count     (set_count_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_action     (s_tuser),
        .in_a          (s_tdata[3:0]),
        .in_b          (s_tdata[7:4]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (m_tuser),
        .out_connected (connected),
        .out_leader_a  (leader_a),
        .out_leader_b  (leader_b),
        .cmd           (cmd),
        .rsp           (rsp)
    );

    assign m_tdata = {7'd0, leader_b, leader_a, connected};

endmodule

// ===== src/uf_table.sv =====
// Parent and rank storage: one shared read address, one write port each.
// Depends on uf_pkg.
module uf_table (
    input  logic             aclk,
    input  logic             aresetn,
    input  uf_pkg::tbl_cmd_t cmd,
    output uf_pkg::tbl_rsp_t rsp
);

    logic [uf_pkg::UF_IDX_W-1:0]  parent_reg [uf_pkg::UF_SIZE];
    logic [uf_pkg::UF_RANK_W-1:0] rank_reg   [uf_pkg::UF_SIZE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < uf_pkg::UF_SIZE; i++) begin
                parent_reg[i] <= uf_pkg::UF_IDX_W'(i);
                rank_reg[i]   <= '0;
            end
        end else begin
            if (cmd.par_we) begin
                parent_reg[cmd.par_addr] <= cmd.par_data;
            end
            if (cmd.rank_we) begin
                rank_reg[cmd.rank_addr] <= cmd.rank_data;
            end
        end
    end

    assign rsp.parent = parent_reg[cmd.rd_addr];
    assign rsp.rank   = rank_reg[cmd.rd_addr];

endmodule

// ===== src/uf_seq.sv =====
// Sequencer: root walks, path compression, linking and init sweep,
// plus the result register. Depends on uf_pkg.
module uf_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [uf_pkg::UF_CFG_W-1:0]   set_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [uf_pkg::UF_ACT_W-1:0]   in_action,
    input  logic [uf_pkg::UF_ELEM_W-1:0]  in_a,
    input  logic [uf_pkg::UF_ELEM_W-1:0]  in_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_status,
    output logic                          out_connected,
    output logic [uf_pkg::UF_ELEM_W-1:0]  out_leader_a,
    output logic [uf_pkg::UF_ELEM_W-1:0]  out_leader_b,
    output uf_pkg::tbl_cmd_t              cmd,
    input  uf_pkg::tbl_rsp_t              rsp
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_INIT  = 9'b000000010,
        ST_FINDA = 9'b000000100,
        ST_CMPA  = 9'b000001000,
        ST_FINDB = 9'b000010000,
        ST_CMPB  = 9'b000100000,
        ST_RANKA = 9'b001000000,
        ST_LINK  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    localparam int IW = uf_pkg::UF_IDX_W;
    localparam int CW = uf_pkg::UF_CNT_W;

    state_t                     state_reg, state_next;
    uf_pkg::op_t                op_reg, op_next;
    logic [IW-1:0]              b_reg, b_next;
    logic [IW-1:0]              a_reg, a_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [IW-1:0]              node_reg, node_next;
    logic [IW-1:0]              ra_reg, ra_next;
    logic [IW-1:0]              rb_reg, rb_next;
    logic [uf_pkg::UF_RANK_W-1:0] rka_reg, rka_next;
    logic                       rs_reg, rs_next;
    logic                       rc_reg, rc_next;
    logic [IW-1:0]              rla_reg, rla_next;
    logic [IW-1:0]              rlb_reg, rlb_next;
    logic                       ov_reg, ov_next;
    logic                       os_reg, os_next;
    logic                       oc_reg, oc_next;
    logic [IW-1:0]              ola_reg, ola_next;
    logic [IW-1:0]              olb_reg, olb_next;

    logic [CW-1:0]              n_cur;
    logic                       hit;
    logic                       range_bad;

    assign n_cur = (set_count > uf_pkg::UF_CFG_W'(uf_pkg::UF_SIZE))
                 ? CW'(uf_pkg::UF_SIZE) : CW'(set_count);
    assign range_bad = (CW'(in_a) >= n_cur) || (CW'(in_b) >= n_cur);
    // shared compare: node against its parent during walks, against root on compression
    assign hit = (state_reg == ST_FINDA || state_reg == ST_FINDB)
               ? (rsp.parent == node_reg)
               : (node_reg == ((state_reg == ST_CMPA) ? ra_reg : rb_reg));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        node_next  = node_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rka_next   = rka_reg;
        rs_next    = rs_reg;
        rc_next    = rc_reg;
        rla_next   = rla_reg;
        rlb_next   = rlb_reg;
        ov_next    = ov_reg;
        os_next    = os_reg;
        oc_next    = oc_reg;
        ola_next   = ola_reg;
        olb_next   = olb_reg;
        cmd        = '0;
        cmd.rd_addr = node_reg;

        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next  = uf_pkg::op_t'(in_action);
                    a_next   = IW'(in_a);
                    b_next   = IW'(in_b);
                    n_next   = n_cur;
                    cnt_next = '0;
                    node_next = IW'(in_a);
                    rs_next  = 1'b0;
                    rc_next  = 1'b0;
                    rla_next = '0;
                    rlb_next = '0;
                    case (uf_pkg::op_t'(in_action))
                        uf_pkg::OP_INIT: state_next = ST_INIT;
                        uf_pkg::OP_QUERY,
                        uf_pkg::OP_UNION: begin
                            if (range_bad) begin
                                rs_next    = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_FINDA;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT: begin
                if (cnt_reg < n_reg) begin
                    cmd.par_we    = 1'b1;
                    cmd.par_addr  = cnt_reg[IW-1:0];
                    cmd.par_data  = cnt_reg[IW-1:0];
                    cmd.rank_we   = 1'b1;
                    cmd.rank_addr = cnt_reg[IW-1:0];
                    cmd.rank_data = '0;
                    cnt_next      = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FINDA: begin
                if (hit) begin
                    ra_next    = node_reg;
                    node_next  = a_reg;
                    state_next = ST_CMPA;
                end else begin
                    node_next = rsp.parent;
                end
            end
            ST_CMPA: begin
                if (hit) begin
                    node_next  = b_reg;
                    state_next = ST_FINDB;
                end else begin
                    cmd.par_we   = 1'b1;
                    cmd.par_addr = node_reg;
                    cmd.par_data = ra_reg;
                    node_next    = rsp.parent;
                end
            end
            ST_FINDB: begin
                if (hit) begin
                    rb_next    = node_reg;
                    node_next  = b_reg;
                    state_next = ST_CMPB;
                end else begin
                    node_next = rsp.parent;
                end
            end
            ST_CMPB: begin
                if (hit) begin
                    rc_next  = (ra_reg == rb_reg);
                    rla_next = ra_reg;
                    rlb_next = rb_reg;
                    if (op_reg == uf_pkg::OP_UNION && ra_reg != rb_reg) begin
                        node_next  = ra_reg;
                        state_next = ST_RANKA;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cmd.par_we   = 1'b1;
                    cmd.par_addr = node_reg;
                    cmd.par_data = rb_reg;
                    node_next    = rsp.parent;
                end
            end
            ST_RANKA: begin
                rka_next   = rsp.rank;
                node_next  = rb_reg;
                state_next = ST_LINK;
            end
            ST_LINK: begin
                cmd.par_we = 1'b1;
                if (rka_reg < rsp.rank) begin
                    cmd.par_addr = ra_reg;
                    cmd.par_data = rb_reg;
                    rla_next     = rb_reg;
                    rlb_next     = rb_reg;
                end else begin
                    cmd.par_addr = rb_reg;
                    cmd.par_data = ra_reg;
                    rla_next     = ra_reg;
                    rlb_next     = ra_reg;
                    if (rka_reg == rsp.rank && rka_reg != uf_pkg::UF_RANK_MAX) begin
                        cmd.rank_we   = 1'b1;
                        cmd.rank_addr = ra_reg;
                        cmd.rank_data = rka_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!ov_reg || out_ready) begin
                    ov_next    = 1'b1;
                    os_next    = rs_reg;
                    oc_next    = rc_reg;
                    ola_next   = rla_reg;
                    olb_next   = rlb_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        node_reg <= node_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        rka_reg  <= rka_next;
        rs_reg   <= rs_next;
        rc_reg   <= rc_next;
        rla_reg  <= rla_next;
        rlb_reg  <= rlb_next;
        os_reg   <= os_next;
        oc_reg   <= oc_next;
        ola_reg  <= ola_next;
        olb_reg  <= olb_next;
    end

    assign out_valid     = ov_reg;
    assign out_status    = os_reg;
    assign out_connected = oc_reg;
    assign out_leader_a  = uf_pkg::UF_ELEM_W'(ola_reg);
    assign out_leader_b  = uf_pkg::UF_ELEM_W'(olb_reg);

    a_par_we_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.par_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("parent write outside a walk, link or init");

    a_rank_we_link: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rank_we |-> (state_reg == ST_LINK || state_reg == ST_INIT))
        else $error("rank write outside link or init");

    a_conn_leaders: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && oc_reg) |-> (ola_reg == olb_reg))
        else $error("connected result with differing leaders");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && os_reg) |-> (!oc_reg && ola_reg == '0 && olb_reg == '0))
        else $error("error result carries non-zero fields");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for union_find_rank_compress: directed and random table
// operations, predicted by a behavioural disjoint-set model kept in this file.
// Depends on uf_pkg and the union_find_rank_compress RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int ITEM_TARGET   = 1900;
    localparam int CALM_TAIL     = 150;

    typedef struct packed {
        logic       status;
        logic       connected;
        logic [3:0] leader_a;
        logic [3:0] leader_b;
    } link_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // elem_a[3:0], elem_b[7:4]
    logic [1:0]  s_tuser;     // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // connected[0], leader_a[4:1], leader_b[8:5], zero
    logic        m_tuser;     // status

    union_find_rank_compress dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // shadow disjoint-set table
    logic [3:0]                   parent_q [uf_pkg::UF_SIZE];
    logic [uf_pkg::UF_RANK_W-1:0] rank_q   [uf_pkg::UF_SIZE];
    logic [4:0]                   count_q;

    link_result_t expected_links[$];
    link_result_t want;

    bit calm;
    int cycles, mismatches, results_seen;
    int items_sent, unions_sent, queries_sent, inits_sent, cfg_writes;
    int stall_left;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_links.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_links.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_links.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[0] !== want.connected) begin
                    $error("connected: expected %0d, got %0d", want.connected, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[4:1] !== want.leader_a) begin
                    $error("leader_a: expected %0d, got %0d", want.leader_a, m_tdata[4:1]);
                    mismatches++;
                end
                if (m_tdata[8:5] !== want.leader_b) begin
                    $error("leader_b: expected %0d, got %0d", want.leader_b, m_tdata[8:5]);
                    mismatches++;
                end
                if (m_tdata[15:9] !== '0) begin
                    $error("pad: expected 0, got %0h", m_tdata[15:9]);
                    mismatches++;
                end
            end
        end
    end

    // root walk followed by path compression
    function automatic logic [3:0] find_root(logic [3:0] e);
        logic [3:0] node, cur, nxt;
        int steps;
        node  = e;
        steps = 0;
        while (parent_q[node] != node && steps < uf_pkg::UF_SIZE) begin
            node = parent_q[node];
            steps++;
        end
        cur   = e;
        steps = 0;
        while (cur != node && steps < uf_pkg::UF_SIZE) begin
            nxt           = parent_q[cur];
            parent_q[cur] = node;
            cur           = nxt;
            steps++;
        end
        return node;
    endfunction

    function automatic link_result_t dsu_apply(uf_pkg::op_t op, logic [3:0] a, logic [3:0] b);
        link_result_t r;
        int n;
        logic [3:0] ra, rb;
        r = '0;
        n = (count_q < uf_pkg::UF_SIZE) ? int'(count_q) : uf_pkg::UF_SIZE;
        case (op)
            uf_pkg::OP_INIT: begin
                for (int i = 0; i < n; i++) begin
                    parent_q[i] = 4'(i);
                    rank_q[i]   = '0;
                end
            end
            uf_pkg::OP_QUERY, uf_pkg::OP_UNION: begin
                if (a >= n || b >= n) begin
                    r.status = 1'b1;
                end else begin
                    ra = find_root(a);
                    rb = find_root(b);
                    r.connected = (ra == rb);
                    if (op == uf_pkg::OP_UNION && ra != rb) begin
                        if (rank_q[ra] > rank_q[rb]) begin
                            parent_q[rb] = ra;
                        end else if (rank_q[ra] < rank_q[rb]) begin
                            parent_q[ra] = rb;
                            ra = rb;
                        end else begin
                            parent_q[rb] = ra;
                            if (rank_q[ra] < uf_pkg::UF_RANK_MAX)
                                rank_q[ra] = rank_q[ra] + 1'b1;
                        end
                        rb = ra;
                    end
                    r.leader_a = ra;
                    r.leader_b = rb;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(uf_pkg::op_t op, logic [3:0] a, logic [3:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        expected_links.push_back(dsu_apply(op, a, b));
        case (op)
            uf_pkg::OP_INIT:  inits_sent++;
            uf_pkg::OP_QUERY: queries_sent++;
            uf_pkg::OP_UNION: unions_sent++;
            default: ;
        endcase
        if (op != uf_pkg::OP_NONE)
            items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_links.size() != 0) @(posedge aclk);
    endtask

    // always followed by at least one beat before the next write
    task automatic write_count(logic [4:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_q = v;
        cfg_writes++;
    endtask

    task automatic test_reset_state();
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd15);
        send_item(uf_pkg::OP_QUERY, 4'd15, 4'd15);
        send_item(uf_pkg::OP_UNION, 4'd0, 4'd15);
        send_item(uf_pkg::OP_NONE, 4'd15, 4'd15);
        send_item(uf_pkg::OP_UNION, 4'd3, 4'd12);
        send_item(uf_pkg::OP_UNION, 4'd12, 4'd15);
        send_item(uf_pkg::OP_QUERY, 4'd15, 4'd0);
        send_item(uf_pkg::OP_INIT, 4'd15, 4'd15);
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd15);
    endtask

    task automatic test_count_limits();
        write_count(5'd1);
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd0);
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd1);
        send_item(uf_pkg::OP_UNION, 4'd1, 4'd0);
        write_count(5'd0);
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd0);
        send_item(uf_pkg::OP_UNION, 4'd15, 4'd15);
        send_item(uf_pkg::OP_INIT, 4'd0, 4'd0);
        write_count(5'd31);
        send_item(uf_pkg::OP_UNION, 4'd15, 4'd14);
        send_item(uf_pkg::OP_QUERY, 4'd14, 4'd15);
    endtask

    // links above the count survive a partial init and are still walked
    task automatic test_shrink_keeps_links();
        write_count(5'd16);
        send_item(uf_pkg::OP_INIT, 4'd0, 4'd0);
        send_item(uf_pkg::OP_UNION, 4'd10, 4'd2);
        send_item(uf_pkg::OP_UNION, 4'd11, 4'd10);
        send_item(uf_pkg::OP_UNION, 4'd5, 4'd11);
        write_count(5'd4);
        send_item(uf_pkg::OP_INIT, 4'd0, 4'd0);
        send_item(uf_pkg::OP_UNION, 4'd3, 4'd7);
        send_item(uf_pkg::OP_UNION, 4'd2, 4'd1);
        write_count(5'd16);
        send_item(uf_pkg::OP_QUERY, 4'd11, 4'd5);
        send_item(uf_pkg::OP_QUERY, 4'd10, 4'd1);
    endtask

    // element e becomes a root of rank r (capped at UF_RANK_MAX), using only elements below it
    task automatic build_rank(int e, int r);
        if (r == 0) begin
            write_count(5'(e + 1));
            send_item(uf_pkg::OP_INIT, 4'd0, 4'd0);
        end else begin
            build_rank(e, r - 1);
            build_rank(e - 1, r - 1);
            write_count(5'(e + 1));
            send_item(uf_pkg::OP_UNION, 4'(e), 4'(e - 1));
        end
    endtask

    // push a rank past 7; a wrapped rank would let 14 absorb 15
    task automatic test_rank_saturation();
        build_rank(15, 8);
        build_rank(14, 1);
        write_count(5'd16);
        send_item(uf_pkg::OP_UNION, 4'd14, 4'd15);
        send_item(uf_pkg::OP_QUERY, 4'd0, 4'd15);
    endtask

    task automatic test_random_phases(int target);
        int n, len, pick, union_pct;
        logic [4:0] cnt;
        uf_pkg::op_t op;
        logic [3:0] a, b;
        while (items_sent < target) begin
            if (items_sent > target - CALM_TAIL)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0:       cnt = 5'd0;
                1:       cnt = 5'd1;
                2:       cnt = 5'd2;
                3, 4:    cnt = 5'd16;
                5:       cnt = 5'd31;
                default: cnt = 5'($urandom_range(3, 31));
            endcase
            write_count(cnt);
            n = (cnt < uf_pkg::UF_SIZE) ? int'(cnt) : uf_pkg::UF_SIZE;
            if ($urandom_range(0, 4) != 0)
                send_item(uf_pkg::OP_INIT, 4'($urandom), 4'($urandom));
            len       = (n == 0) ? $urandom_range(3, 8) : $urandom_range(20, 70);
            union_pct = $urandom_range(20, 80);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = uf_pkg::OP_INIT;
                else if (pick < 7)
                    op = uf_pkg::OP_NONE;
                else if ($urandom_range(0, 99) < union_pct)
                    op = uf_pkg::OP_UNION;
                else
                    op = uf_pkg::OP_QUERY;
                if (n > 0 && pick >= 12) begin
                    a = 4'($urandom_range(0, n - 1));
                    b = 4'($urandom_range(0, n - 1));
                end else begin
                    a = 4'($urandom);
                    b = 4'($urandom);
                end
                send_item(op, a, b);
            end
        end
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        calm       = 1'b0;
        stall_left = 0;
        count_q    = 5'd16;
        for (int i = 0; i < uf_pkg::UF_SIZE; i++) begin
            parent_q[i] = 4'(i);
            rank_q[i]   = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_count_limits();
        test_shrink_keeps_links();
        test_rank_saturation();
        test_random_phases(ITEM_TARGET);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_links.size() != 0) begin
            $error("%0d expected results never arrived", expected_links.size());
            mismatches++;
        end

        $display("Ran %0d table operations: %0d unions, %0d queries, %0d inits.",
                 items_sent, unions_sent, queries_sent, inits_sent);
        $display("Element count rewritten %0d times; %0d result beats checked.",
                 cfg_writes, results_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
